@@ design/mtep_pkg.sv @@
// Package for the MIDI track event parser: parse phases, control states,
// byte codes, result kinds, error codes and the beat structures.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

   // Track chunk magic and key/channel slot geometry.
   localparam logic [31:0] CHUNK_MAGIC = 32'h4D54726B;
   localparam int          KEY_CHANNEL_SLOTS = 2048;
   localparam int          SLOT_W = 11;

   // Event byte codes.
   localparam logic [7:0] BYTE_META     = 8'hFF;
   localparam logic [7:0] META_END      = 8'h2F;
   localparam logic [7:0] META_TEMPO    = 8'h51;
   localparam logic [7:0] META_TIME_SIG = 8'h58;
   localparam logic [7:0] BYTE_SYSEX    = 8'hF0;
   localparam logic [7:0] BYTE_ESCAPE   = 8'hF7;
   localparam logic [7:0] BYTE_SONG_POS = 8'hF2;
   localparam logic [7:0] BYTE_SONG_SEL = 8'hF3;
   localparam logic [7:0] BYTE_REALTIME = 8'hF8;

   // Status high nibbles.
   localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
   localparam logic [3:0] ST_NOTE_ON   = 4'h9;
   localparam logic [3:0] ST_POLY_AT   = 4'hA;
   localparam logic [3:0] ST_CONTROL   = 4'hB;
   localparam logic [3:0] ST_PROGRAM   = 4'hC;
   localparam logic [3:0] ST_CHAN_AT   = 4'hD;
   localparam logic [3:0] ST_PITCH     = 4'hE;

   localparam logic [4:0] NO_CHANNEL = 5'd16;

   // Result kinds.
   localparam logic [2:0] KIND_NOTE_START = 3'd0;
   localparam logic [2:0] KIND_NOTE_END   = 3'd1;
   localparam logic [2:0] KIND_CHAN_MSG   = 3'd2;
   localparam logic [2:0] KIND_TEMPO      = 3'd3;
   localparam logic [2:0] KIND_TIME_SIG   = 3'd4;
   localparam logic [2:0] KIND_TRACK_END  = 3'd5;

   // Error codes reported at track end.
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_HEADER = 3'd1;
   localparam logic [2:0] ERR_META_LONG  = 3'd2;
   localparam logic [2:0] ERR_SYSEX_LONG = 3'd3;
   localparam logic [2:0] ERR_ZERO_TEMPO = 3'd4;

   // Configuration register addresses (byte address bit 2).
   localparam logic REG_NOTES_ONLY   = 1'b0;
   localparam logic REG_TRACK_NUMBER = 1'b1;

   typedef enum logic [3:0] {
      PH_HEADER    = 4'd0,
      PH_DELTA     = 4'd1,
      PH_EVENT     = 4'd2,
      PH_META_TYPE = 4'd3,
      PH_META_LEN  = 4'd4,
      PH_META_DATA = 4'd5,
      PH_SYSEX_LEN = 4'd6,
      PH_SKIP      = 4'd7,
      PH_DATA1     = 4'd8,
      PH_DATA2     = 4'd9,
      PH_DONE      = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      CTL_CLEAR = 2'd0,
      CTL_RUN   = 2'd1,
      CTL_CLOSE = 2'd2
   } ctl_type;

   // A classified input byte as it travels from front to back.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_start;
      logic       is_meta;
      logic       is_sysex;
      logic       is_common;
      logic       is_realtime;
      logic       is_status;
   } item_type;

   // One result beat.
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] tick;
      logic [31:0] note_id;
      logic [3:0]  channel;
      logic [6:0]  key;
      logic [31:0] value;
      logic [2:0]  error_code;
      logic        multi_channel;
      logic        last;
   } res_type;

   function automatic res_type mk_res(input logic [2:0] kind, input logic [31:0] tick,
                                      input logic [31:0] id, input logic [3:0] ch,
                                      input logic [6:0] key, input logic [31:0] val,
                                      input logic [2:0] err, input logic multi);
      res_type r;
      r.kind          = kind;
      r.tick          = tick;
      r.note_id       = id;
      r.channel       = ch;
      r.key           = key;
      r.value         = val;
      r.error_code    = err;
      r.multi_channel = multi;
      r.last          = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/mtep_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mtep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/mtep_front.sv @@
// Front end of the parser: accepts input beats, classifies each byte and
// holds it in a two-entry queue for the back end. Depends on mtep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtep_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic [0:0]        req_tuser,
   output logic                   head_valid,
   output mtep_pkg::item_type     head,
   input  wire logic              head_pop
);

   mtep_pkg::item_type q_ff [2];
   logic               wp_ff, wp_in;
   logic               rp_ff, rp_in;
   logic [1:0]         cnt_ff, cnt_in;
   mtep_pkg::item_type item;
   logic               push;

   // Classify the incoming byte.
   always_comb begin
      item.data_byte   = req_tdata;
      item.chunk_start = req_tuser[0];
      item.is_meta     = (req_tdata == mtep_pkg::BYTE_META);
      item.is_sysex    = (req_tdata == mtep_pkg::BYTE_SYSEX) ||
                         (req_tdata == mtep_pkg::BYTE_ESCAPE);
      item.is_common   = (req_tdata == mtep_pkg::BYTE_SONG_POS) ||
                         (req_tdata == mtep_pkg::BYTE_SONG_SEL);
      item.is_realtime = (req_tdata >= mtep_pkg::BYTE_REALTIME);
      item.is_status   = req_tdata[7];
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[rp_ff];

   // Queue pointers.
   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ head_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= item;
      end
   end

endmodule

`default_nettype wire

@@ design/mtep_back.sv @@
// Back end of the parser: runs the track state machine on each queued byte,
// pairs notes through the count and stack RAMs, and buffers result beats.
// Depends on mtep_pkg and mtep_ram.
`timescale 1ns / 1ps
`default_nettype none

module mtep_back #(
   parameter int STACK_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               notes_only,
   input  wire logic               head_valid,
   input  wire mtep_pkg::item_type head,
   output logic                    head_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output mtep_pkg::res_type       rsp
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(mtep_pkg::KEY_CHANNEL_SLOTS * STACK_DEPTH);
   localparam int SW = mtep_pkg::SLOT_W;

   // Track state.
   mtep_pkg::phase_type phase_ff, phase_in;
   logic [31:0] tick_ff, tick_in;
   logic [31:0] vacc_ff, vacc_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] skip_ff, skip_in;
   logic [7:0]  rs_ff, rs_in;
   logic [7:0]  mtype_ff, mtype_in;
   logic [23:0] pay_ff, pay_in;
   logic [7:0]  fd_ff, fd_in;
   logic [4:0]  fch_ff, fch_in;
   logic        mixed_ff, mixed_in;
   logic [31:0] nid_ff, nid_in;

   // Control.
   mtep_pkg::ctl_type ctl_ff, ctl_in;
   logic [SW-1:0] clr_ptr_ff, clr_ptr_in;
   logic          swept_ff, swept_in;
   logic          pop, close_go, sweep, room, defer;

   // RAM ports.
   logic          cnt_we, cnt_re;
   logic [SW-1:0] cnt_waddr, cnt_raddr;
   logic [CW-1:0] cnt_wdata, cnt_rdata;
   logic          stk_we, stk_re;
   logic [AW-1:0] stk_waddr, stk_raddr;
   logic [63:0]   stk_wdata, stk_rdata;

   // Per-byte results.
   logic              ev_valid, fin_valid;
   mtep_pkg::res_type ev_res, fin_res, r0, r1;
   logic [2:0]        fin_err;
   logic [1:0]        n_res;

   // Output queue.
   mtep_pkg::res_type oq_ff [4];
   logic [1:0] oq_wp_ff, oq_wp_in, oq_rp_ff, oq_rp_in;
   logic [2:0] oq_cnt_ff, oq_cnt_in;
   logic       oq_pop;

   assign room = (oq_cnt_ff <= 3'd2);

   // Control state machine: next state.
   always_comb begin
      ctl_in = ctl_ff;
      unique case (ctl_ff)
         mtep_pkg::CTL_CLEAR: begin
            if (clr_ptr_ff == {SW{1'b1}}) ctl_in = mtep_pkg::CTL_RUN;
         end
         mtep_pkg::CTL_RUN: begin
            if (head_valid && head.chunk_start && !swept_ff) ctl_in = mtep_pkg::CTL_CLEAR;
            else if (defer) ctl_in = mtep_pkg::CTL_CLOSE;
         end
         mtep_pkg::CTL_CLOSE: begin
            if (room) ctl_in = mtep_pkg::CTL_RUN;
         end
         default: ctl_in = mtep_pkg::CTL_CLEAR;
      endcase
   end

   // Control state machine: outputs.
   always_comb begin
      pop      = 1'b0;
      close_go = 1'b0;
      sweep    = 1'b0;
      unique case (ctl_ff)
         mtep_pkg::CTL_CLEAR: sweep = 1'b1;
         mtep_pkg::CTL_RUN:
            pop = head_valid && room && !(head.chunk_start && !swept_ff);
         mtep_pkg::CTL_CLOSE: close_go = room;
         default: sweep = 1'b0;
      endcase
   end

   assign head_pop = pop;

   // Sweep pointer and the flag that the counts were just cleared.
   always_comb begin
      clr_ptr_in = sweep ? clr_ptr_ff + 1'b1 : '0;
      swept_in   = swept_ff;
      if (sweep && (clr_ptr_ff == {SW{1'b1}})) swept_in = 1'b1;
      else if (pop) swept_in = 1'b0;
   end

   // Byte parser.
   always_comb begin
      logic [7:0]    b;
      logic [3:0]    hi;
      logic [3:0]    ch;
      logic [31:0]   len_v;
      logic [31:0]   pos_v;
      logic          md_req;
      logic [31:0]   md_len;
      logic          td1_req;
      logic [SW-1:0] slot;

      b       = head.data_byte;
      hi      = 4'h0;
      ch      = 4'h0;
      len_v   = '0;
      pos_v   = '0;
      md_req  = 1'b0;
      md_len  = '0;
      td1_req = 1'b0;
      slot    = '0;

      phase_in = phase_ff;
      tick_in  = tick_ff;
      vacc_in  = vacc_ff;
      left_in  = left_ff;
      skip_in  = skip_ff;
      rs_in    = rs_ff;
      mtype_in = mtype_ff;
      pay_in   = pay_ff;
      fd_in    = fd_ff;
      fch_in   = fch_ff;
      mixed_in = mixed_ff;
      nid_in   = nid_ff;

      ev_valid  = 1'b0;
      ev_res    = '0;
      fin_valid = 1'b0;
      fin_err   = mtep_pkg::ERR_NONE;
      defer     = 1'b0;

      cnt_we    = 1'b0;
      cnt_waddr = '0;
      cnt_wdata = '0;
      cnt_re    = 1'b0;
      cnt_raddr = '0;
      stk_we    = 1'b0;
      stk_waddr = '0;
      stk_wdata = '0;
      stk_re    = 1'b0;
      stk_raddr = '0;

      if (pop) begin
         // A chunk start clears the per-track state before the byte is used.
         if (head.chunk_start) begin
            phase_in = mtep_pkg::PH_HEADER;
            tick_in  = '0;
            vacc_in  = '0;
            left_in  = '0;
            skip_in  = '0;
            rs_in    = '0;
            mtype_in = '0;
            pay_in   = '0;
            fd_in    = '0;
            fch_in   = mtep_pkg::NO_CHANNEL;
            mixed_in = 1'b0;
            nid_in   = '0;
         end

         if (phase_in == mtep_pkg::PH_HEADER) begin
            // Magic word, then the big-endian chunk length.
            vacc_in = {vacc_in[23:0], b};
            skip_in = skip_in + 32'd1;
            if (skip_in == 32'd4) begin
               if (vacc_in != mtep_pkg::CHUNK_MAGIC) begin
                  fin_valid = 1'b1;
                  fin_err   = mtep_pkg::ERR_BAD_HEADER;
                  phase_in  = mtep_pkg::PH_DONE;
               end
               vacc_in = '0;
            end else if (skip_in >= 32'd8) begin
               left_in = vacc_in;
               vacc_in = '0;
               skip_in = '0;
               if (left_in == 32'd0) begin
                  fin_valid = 1'b1;
                  phase_in  = mtep_pkg::PH_DONE;
               end else begin
                  phase_in = mtep_pkg::PH_DELTA;
               end
            end
         end else if (phase_in != mtep_pkg::PH_DONE) begin
            left_in = left_in - 32'd1;
            unique case (phase_in)
               mtep_pkg::PH_DELTA: begin
                  vacc_in = {vacc_in[24:0], b[6:0]};
                  if (!b[7]) begin
                     tick_in  = tick_in + vacc_in;
                     vacc_in  = '0;
                     phase_in = mtep_pkg::PH_EVENT;
                  end
               end
               mtep_pkg::PH_EVENT: begin
                  vacc_in = '0;
                  priority if (head.is_meta) begin
                     phase_in = mtep_pkg::PH_META_TYPE;
                  end else if (head.is_sysex) begin
                     phase_in = mtep_pkg::PH_SYSEX_LEN;
                  end else if (head.is_common) begin
                     skip_in  = (b == mtep_pkg::BYTE_SONG_POS) ? 32'd2 : 32'd1;
                     phase_in = mtep_pkg::PH_SKIP;
                  end else if (head.is_realtime) begin
                     phase_in = mtep_pkg::PH_DELTA;
                  end else if (head.is_status) begin
                     rs_in    = b;
                     phase_in = mtep_pkg::PH_DATA1;
                  end else begin
                     td1_req = 1'b1;
                  end
               end
               mtep_pkg::PH_META_TYPE: begin
                  mtype_in = b;
                  vacc_in  = '0;
                  phase_in = mtep_pkg::PH_META_LEN;
               end
               mtep_pkg::PH_META_LEN: begin
                  vacc_in = {vacc_in[24:0], b[6:0]};
                  if (!b[7]) begin
                     len_v  = vacc_in;
                     pay_in = '0;
                     fd_in  = '0;
                     if (len_v > left_in) begin
                        fin_valid = 1'b1;
                        fin_err   = mtep_pkg::ERR_META_LONG;
                        phase_in  = mtep_pkg::PH_DONE;
                     end else if (len_v == 32'd0) begin
                        md_req = 1'b1;
                        md_len = '0;
                     end else begin
                        skip_in  = len_v;
                        phase_in = mtep_pkg::PH_META_DATA;
                     end
                  end
               end
               mtep_pkg::PH_META_DATA: begin
                  pos_v = vacc_in - skip_in;
                  if (mtype_in == mtep_pkg::META_TIME_SIG) begin
                     if (pos_v == 32'd0) fd_in = b;
                     else if (pos_v == 32'd1)
                        pay_in = (b < 8'd8) ? (24'd1 << b[2:0]) : 24'd0;
                  end else begin
                     pay_in = {pay_in[15:0], b};
                  end
                  skip_in = skip_in - 32'd1;
                  if (skip_in == 32'd0) begin
                     md_req = 1'b1;
                     md_len = vacc_in;
                  end
               end
               mtep_pkg::PH_SYSEX_LEN: begin
                  vacc_in = {vacc_in[24:0], b[6:0]};
                  if (!b[7]) begin
                     len_v   = vacc_in;
                     vacc_in = '0;
                     if (len_v > left_in) begin
                        fin_valid = 1'b1;
                        fin_err   = mtep_pkg::ERR_SYSEX_LONG;
                        phase_in  = mtep_pkg::PH_DONE;
                     end else if (len_v == 32'd0) begin
                        phase_in = mtep_pkg::PH_DELTA;
                     end else begin
                        skip_in  = len_v;
                        phase_in = mtep_pkg::PH_SKIP;
                     end
                  end
               end
               mtep_pkg::PH_SKIP: begin
                  if (skip_in != 32'd0) skip_in = skip_in - 32'd1;
                  if (skip_in == 32'd0) begin
                     vacc_in  = '0;
                     phase_in = mtep_pkg::PH_DELTA;
                  end
               end
               mtep_pkg::PH_DATA1: begin
                  td1_req = 1'b1;
               end
               mtep_pkg::PH_DATA2: begin
                  hi       = rs_in[7:4];
                  ch       = rs_in[3:0];
                  slot     = {fd_in[6:0], ch};
                  phase_in = mtep_pkg::PH_DELTA;
                  vacc_in  = '0;
                  if ((hi == mtep_pkg::ST_NOTE_OFF) || (hi == mtep_pkg::ST_NOTE_ON)) begin
                     if (!fd_in[7]) begin
                        if ((hi == mtep_pkg::ST_NOTE_ON) && (b != 8'd0)) begin
                           // Note start: push onto the slot's stack unless full.
                           ev_valid = 1'b1;
                           ev_res   = mtep_pkg::mk_res(mtep_pkg::KIND_NOTE_START, tick_in,
                                         nid_in, ch, fd_in[6:0], {24'd0, b},
                                         mtep_pkg::ERR_NONE, 1'b0);
                           if (cnt_rdata < CW'(STACK_DEPTH)) begin
                              stk_we    = 1'b1;
                              stk_waddr = AW'(slot) * AW'(STACK_DEPTH) + AW'(cnt_rdata);
                              stk_wdata = {nid_in, tick_in};
                              cnt_we    = 1'b1;
                              cnt_waddr = slot;
                              cnt_wdata = cnt_rdata + 1'b1;
                           end
                           nid_in = nid_in + 32'd1;
                        end else if ((cnt_rdata != '0) &&
                                     (cnt_rdata <= CW'(STACK_DEPTH))) begin
                           // Note end: pop the stack; the result is built in CLOSE.
                           cnt_we    = 1'b1;
                           cnt_waddr = slot;
                           cnt_wdata = cnt_rdata - 1'b1;
                           stk_re    = 1'b1;
                           stk_raddr = AW'(slot) * AW'(STACK_DEPTH) + AW'(cnt_rdata - 1'b1);
                           defer     = 1'b1;
                        end
                     end
                  end else if (!notes_only) begin
                     ev_valid = 1'b1;
                     ev_res   = mtep_pkg::mk_res(mtep_pkg::KIND_CHAN_MSG, tick_in, '0, '0, '0,
                                   {8'd0, b, fd_in, rs_in}, mtep_pkg::ERR_NONE, 1'b0);
                  end
               end
               default: phase_in = mtep_pkg::PH_DONE;
            endcase

            // First data byte of a channel message.
            if (td1_req) begin
               hi       = rs_in[7:4];
               ch       = rs_in[3:0];
               fd_in    = b;
               phase_in = mtep_pkg::PH_DELTA;
               vacc_in  = '0;
               if (rs_in[7] && (hi <= mtep_pkg::ST_PITCH) && !mixed_in) begin
                  if (fch_in == mtep_pkg::NO_CHANNEL) fch_in = {1'b0, ch};
                  else if ({1'b0, ch} != fch_in) mixed_in = 1'b1;
               end
               if ((hi == mtep_pkg::ST_PROGRAM) || (hi == mtep_pkg::ST_CHAN_AT)) begin
                  if (!notes_only) begin
                     ev_valid = 1'b1;
                     ev_res   = mtep_pkg::mk_res(mtep_pkg::KIND_CHAN_MSG, tick_in, '0, '0, '0,
                                   {16'd0, b, rs_in}, mtep_pkg::ERR_NONE, 1'b0);
                  end
               end else if ((hi == mtep_pkg::ST_NOTE_OFF) || (hi == mtep_pkg::ST_NOTE_ON) ||
                            (hi == mtep_pkg::ST_POLY_AT) || (hi == mtep_pkg::ST_CONTROL) ||
                            (hi == mtep_pkg::ST_PITCH)) begin
                  phase_in = mtep_pkg::PH_DATA2;
                  if ((hi == mtep_pkg::ST_NOTE_OFF) || (hi == mtep_pkg::ST_NOTE_ON)) begin
                     // Fetch the stack fill for this key and channel.
                     cnt_re    = 1'b1;
                     cnt_raddr = {b[6:0], ch};
                  end
               end
            end

            // End of a meta event.
            if (md_req) begin
               phase_in = mtep_pkg::PH_DELTA;
               vacc_in  = '0;
               if (mtype_in == mtep_pkg::META_END) begin
                  fin_valid = 1'b1;
                  phase_in  = mtep_pkg::PH_DONE;
               end else if ((mtype_in == mtep_pkg::META_TEMPO) && (md_len == 32'd3)) begin
                  if (pay_in == 24'd0) begin
                     fin_valid = 1'b1;
                     fin_err   = mtep_pkg::ERR_ZERO_TEMPO;
                     phase_in  = mtep_pkg::PH_DONE;
                  end else begin
                     ev_valid = 1'b1;
                     ev_res   = mtep_pkg::mk_res(mtep_pkg::KIND_TEMPO, tick_in, '0, '0, '0,
                                   {8'd0, pay_in}, mtep_pkg::ERR_NONE, 1'b0);
                  end
               end else if ((mtype_in == mtep_pkg::META_TIME_SIG) && (md_len == 32'd4)) begin
                  ev_valid = 1'b1;
                  ev_res   = mtep_pkg::mk_res(mtep_pkg::KIND_TIME_SIG, tick_in, '0, '0, '0,
                                {16'd0, fd_in, 8'd0} | {8'd0, pay_in},
                                mtep_pkg::ERR_NONE, 1'b0);
               end
            end

            // The byte that uses up the chunk ends the track.
            if (!defer && (phase_in != mtep_pkg::PH_DONE) && (left_in == 32'd0)) begin
               fin_valid = 1'b1;
               phase_in  = mtep_pkg::PH_DONE;
            end
         end
      end else if (close_go) begin
         // Completion of a note end: the stack entry is here.
         ev_valid = 1'b1;
         ev_res   = mtep_pkg::mk_res(mtep_pkg::KIND_NOTE_END, tick_ff, stk_rdata[63:32],
                       rs_ff[3:0], fd_ff[6:0], tick_ff - stk_rdata[31:0],
                       mtep_pkg::ERR_NONE, 1'b0);
         if (left_ff == 32'd0) begin
            fin_valid = 1'b1;
            phase_in  = mtep_pkg::PH_DONE;
         end
      end

      // The sweep clears the counts one slot a cycle.
      if (sweep) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_ptr_ff;
         cnt_wdata = '0;
      end
   end

   // Order the results of one byte and mark the last.
   always_comb begin
      fin_res      = mtep_pkg::mk_res(mtep_pkg::KIND_TRACK_END, tick_in, '0, '0, '0, '0,
                                      fin_err, mixed_in);
      fin_res.last = 1'b1;
      n_res        = {1'b0, ev_valid} + {1'b0, fin_valid};
      r1           = fin_res;
      if (ev_valid) begin
         r0      = ev_res;
         r0.last = !fin_valid;
      end else begin
         r0 = fin_res;
      end
   end

   // Output queue: up to two beats in, one beat out per cycle while rsp_ready is high.
   assign oq_pop    = rsp_valid && rsp_ready;
   assign rsp_valid = (oq_cnt_ff != 3'd0);
   assign rsp       = oq_ff[oq_rp_ff];

   always_comb begin
      oq_wp_in  = oq_wp_ff + n_res;
      oq_rp_in  = oq_rp_ff + {1'b0, oq_pop};
      oq_cnt_in = oq_cnt_ff + {1'b0, n_res} - {2'd0, oq_pop};
   end

   always_ff @(posedge clock) begin
      if (n_res != 2'd0) oq_ff[oq_wp_ff] <= r0;
      if (n_res == 2'd2) oq_ff[oq_wp_ff + 2'd1] <= r1;
   end

   // Control and track state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff     <= mtep_pkg::CTL_CLEAR;
         clr_ptr_ff <= '0;
         swept_ff   <= 1'b0;
         oq_wp_ff   <= '0;
         oq_rp_ff   <= '0;
         oq_cnt_ff  <= '0;
         phase_ff   <= mtep_pkg::PH_HEADER;
         tick_ff    <= '0;
         vacc_ff    <= '0;
         left_ff    <= '0;
         skip_ff    <= '0;
         rs_ff      <= '0;
         mtype_ff   <= '0;
         pay_ff     <= '0;
         fd_ff      <= '0;
         fch_ff     <= mtep_pkg::NO_CHANNEL;
         mixed_ff   <= 1'b0;
         nid_ff     <= '0;
      end else begin
         ctl_ff     <= ctl_in;
         clr_ptr_ff <= clr_ptr_in;
         swept_ff   <= swept_in;
         oq_wp_ff   <= oq_wp_in;
         oq_rp_ff   <= oq_rp_in;
         oq_cnt_ff  <= oq_cnt_in;
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         vacc_ff    <= vacc_in;
         left_ff    <= left_in;
         skip_ff    <= skip_in;
         rs_ff      <= rs_in;
         mtype_ff   <= mtype_in;
         pay_ff     <= pay_in;
         fd_ff      <= fd_in;
         fch_ff     <= fch_in;
         mixed_ff   <= mixed_in;
         nid_ff     <= nid_in;
      end
   end

   // Stack fill per key and channel.
   mtep_ram #(
      .WIDTH(CW),
      .DEPTH(mtep_pkg::KEY_CHANNEL_SLOTS)
   ) u_count_ram (
      .clock  (clock),
      .wr_en  (cnt_we),
      .wr_addr(cnt_waddr),
      .wr_data(cnt_wdata),
      .rd_en  (cnt_re),
      .rd_addr(cnt_raddr),
      .rd_data(cnt_rdata)
   );

   // Open note entries: note id over start tick.
   mtep_ram #(
      .WIDTH(64),
      .DEPTH(mtep_pkg::KEY_CHANNEL_SLOTS * STACK_DEPTH)
   ) u_stack_ram (
      .clock  (clock),
      .wr_en  (stk_we),
      .wr_addr(stk_waddr),
      .wr_data(stk_wdata),
      .rd_en  (stk_re),
      .rd_addr(stk_raddr),
      .rd_data(stk_rdata)
   );

`ifndef SYNTHESIS
   // No byte is taken while the counts are swept or a note end completes.
   a_pop_only_run: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff != mtep_pkg::CTL_RUN) |-> !pop)
      else $error("byte taken outside run state");

   // A popped note end always moves to the completion state.
   a_defer_close: assert property (@(posedge clock) disable iff (reset)
      (pop && defer) |=> (ctl_ff == mtep_pkg::CTL_CLOSE))
      else $error("note end not completed");

   // The output queue never overflows.
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_cnt_ff <= 3'd4)
      else $error("output queue overflow");

   // The tick holds while a note end completes.
   a_close_tick: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == mtep_pkg::CTL_CLOSE) |=> $stable(tick_ff))
      else $error("tick moved during note end");
`endif

endmodule

`default_nettype wire

@@ design/midi_track_event_parser.sv @@
// Top level of the MIDI track event parser: configuration registers and the
// front and back ends. Depends on mtep_pkg, mtep_front and mtep_back.
//
//   Channel  Direction  Handshake               Beat
//   req_     in         tvalid/tready           one byte of the track chunk
//   rsp_     out        tvalid/tready, tlast    one event result
//   csr_     in/out     psel/penable/pready     register write or read
//
// One byte per cycle while the output queue has room; a byte that ends a note
// holds off the next byte for the stack read, and at most two results leave
// per byte. After reset, and before a byte marked as a chunk start unless the
// counts were just swept, the key and channel counts are swept while no byte
// is taken. The input queue holds two bytes, the output queue four results,
// so either side may stall on its own. Reset is synchronous and active high.
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser #(
   parameter int STACK_DEPTH = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // [7:0] data_byte
   input  wire logic [0:0]    req_tuser,   // [0] chunk_start
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [111:0]       rsp_tdata,   // tick, note_id, channel, key, value,
                                           // error_code, multi_channel, pad
   output logic [2:0]         rsp_tuser,   // [2:0] kind
   output logic               rsp_tlast,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [2:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic               notes_only_ff;
   logic [15:0]        track_number_ff;
   logic               cfg_write;
   logic               head_valid;
   logic               head_pop;
   mtep_pkg::item_type head;
   mtep_pkg::res_type  res;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         notes_only_ff   <= 1'b0;
         track_number_ff <= '0;
      end else if (cfg_write) begin
         if (csr_paddr[2] == mtep_pkg::REG_NOTES_ONLY) notes_only_ff <= csr_pwdata[0];
         else track_number_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == mtep_pkg::REG_TRACK_NUMBER) ?
                       {16'd0, track_number_ff} : {31'd0, notes_only_ff};

   mtep_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .head_valid(head_valid),
      .head      (head),
      .head_pop  (head_pop)
   );

   mtep_back #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .notes_only(notes_only_ff),
      .head_valid(head_valid),
      .head      (head),
      .head_pop  (head_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (res)
   );

   // Result beat packing.
   assign rsp_tdata = {1'b0, res.multi_channel, res.error_code, res.value, res.key,
                       res.channel, res.note_id, res.tick};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;

endmodule

`default_nettype wire
